[rtl/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [2:0]         func_t;
  typedef logic [1:0]         status_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam func_t FUNC_PUSH_FRONT = 3'd0;
  localparam func_t FUNC_PUSH_BACK  = 3'd1;
  localparam func_t FUNC_POP_FRONT  = 3'd2;
  localparam func_t FUNC_POP_BACK   = 3'd3;
  localparam func_t FUNC_DUMP_FWD   = 3'd4;
  localparam func_t FUNC_DUMP_BWD   = 3'd5;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,
    CELL_NEXT = 2'd2
  } cell_dir_t;

  typedef struct packed {
    logic      load;
    cell_dir_t dir;
  } cell_ctl_t;

endpackage

[rtl/deq_if.sv]
interface deq_in_if;
  logic                 valid;
  logic                 ready;
  deq_pkg::func_t       func;
  deq_pkg::word_t       value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_out_if;
  logic                 valid;
  logic                 ready;
  deq_pkg::word_t       data_out;
  deq_pkg::status_t     status;
  logic                 last;

  modport source (output valid, output data_out, output status, output last, input ready);
  modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface

[rtl/deq_cell.sv]
module deq_cell (
  input  logic               clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  deq_pkg::word_t     prev_q,
  input  deq_pkg::word_t     next_q,
  input  deq_pkg::word_t     load_val,
  output deq_pkg::word_t     q
);

  deq_pkg::word_t q_r;
  deq_pkg::word_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.load) begin
      q_nxt = load_val;
    end else begin
      case (ctl.dir)
        deq_pkg::CELL_PREV: q_nxt = prev_q;
        deq_pkg::CELL_NEXT: q_nxt = next_q;
        default:            q_nxt = q_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

[rtl/double_ended_queue_top.sv]
// Bounded double-ended queue of signed 32-bit words held in a row of
// deq_pkg::DEPTH cells, the front element always in cell 0 and an occupancy
// count marking the back. Push and pop requests answer with one status item
// (ok, empty, or full when a push is refused). A dump of a non-empty queue
// circulates the whole row once, so it occupies the block for the whole turn
// plus any output stall, emitting one item per element with the final one
// marked last; the row ends back in its original order. A dump of
// an empty queue answers with a single empty item. Function codes 6 and 7 are
// accepted and ignored. The next request is taken once the output register is
// empty or its item leaves in the same cycle, and never during a dump.
module double_ended_queue_top (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_if,
  deq_out_if.source out_if
);

  localparam int D = deq_pkg::DEPTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  deq_pkg::cnt_t     count_r, count_nxt;
  deq_pkg::idx_t     step_r, step_nxt;
  logic              bwd_r, bwd_nxt;

  logic              out_valid_r, out_valid_nxt;
  deq_pkg::word_t    out_data_r, out_data_nxt;
  deq_pkg::status_t  out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              push_front, push_back, pop_front, rot_left, rot_right;
  logic              slot_free, in_acc, emit, advance;

  deq_pkg::word_t    cell_q [D];
  deq_pkg::cell_ctl_t cell_ctl [D];

  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && slot_free;
  assign in_acc      = in_if.valid && in_if.ready;

  assign emit = bwd_r ? (deq_pkg::cnt_t'(step_r) >= (deq_pkg::cnt_t'(D) - count_r))
                      : (deq_pkg::cnt_t'(step_r) < count_r);
  assign advance = (state_r == S_DUMP) && (!emit || slot_free);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    bwd_nxt        = bwd_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    push_front     = 1'b0;
    push_back      = 1'b0;
    pop_front      = 1'b0;
    rot_left       = 1'b0;
    rot_right      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_data_nxt = '0;
          out_last_nxt = 1'b1;
          case (in_if.func)
            deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == deq_pkg::cnt_t'(D)) begin
                out_status_nxt = deq_pkg::STAT_FULL;
              end else begin
                out_status_nxt = deq_pkg::STAT_OK;
                count_nxt      = count_r + 1'b1;
                push_front     = (in_if.func == deq_pkg::FUNC_PUSH_FRONT);
                push_back      = (in_if.func == deq_pkg::FUNC_PUSH_BACK);
              end
            end
            deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = deq_pkg::STAT_EMPTY;
              end else begin
                out_status_nxt = deq_pkg::STAT_OK;
                count_nxt      = count_r - 1'b1;
                pop_front      = (in_if.func == deq_pkg::FUNC_POP_FRONT);
              end
            end
            deq_pkg::FUNC_DUMP_FWD, deq_pkg::FUNC_DUMP_BWD: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = deq_pkg::STAT_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                step_nxt  = '0;
                bwd_nxt   = (in_if.func == deq_pkg::FUNC_DUMP_BWD);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (advance) begin
          rot_left  = !bwd_r;
          rot_right = bwd_r;
          if (emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = deq_pkg::STAT_OK;
            out_data_nxt   = bwd_r ? cell_q[D-1] : cell_q[0];
            out_last_nxt   = bwd_r ? (step_r == deq_pkg::idx_t'(D - 1))
                                   : (deq_pkg::cnt_t'(step_r) + 1'b1 == count_r);
          end
          if (step_r == deq_pkg::idx_t'(D - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    for (int k = 0; k < D; k++) begin
      cell_ctl[k].load = 1'b0;
      cell_ctl[k].dir  = deq_pkg::CELL_HOLD;
      if (push_front) begin
        cell_ctl[k].load = (k == 0);
        cell_ctl[k].dir  = deq_pkg::CELL_PREV;
      end else if (pop_front || rot_left) begin
        cell_ctl[k].dir = deq_pkg::CELL_NEXT;
      end else if (rot_right) begin
        cell_ctl[k].dir = deq_pkg::CELL_PREV;
      end else if (push_back) begin
        cell_ctl[k].load = (deq_pkg::cnt_t'(k) == count_r);
      end
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    localparam int PREV_K = (k + D - 1) % D;
    localparam int NEXT_K = (k + 1) % D;
    deq_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[k]),
      .prev_q   (cell_q[PREV_K]),
      .next_q   (cell_q[NEXT_K]),
      .load_val (in_if.value),
      .q        (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      bwd_r       <= bwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.data_out = out_data_r;
  assign out_if.status   = out_status_r;
  assign out_if.last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::cnt_t'(D))
    else $error("occupancy above depth");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !in_if.ready)
    else $error("item taken during dump");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_if.func == deq_pkg::FUNC_PUSH_FRONT ||
                in_if.func == deq_pkg::FUNC_PUSH_BACK) &&
     count_r != deq_pkg::cnt_t'(D))
    |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow occupancy");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_r == deq_pkg::idx_t'(D - 1)) |=> state_r == S_IDLE)
    else $error("dump did not finish after one full turn");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> count_r == $past(count_r))
    else $error("occupancy changed during dump");

endmodule

[bench/tb_top.sv]
module tb_top;
  import deq_pkg::*;

  localparam int    LIMIT        = 2_000_000;
  localparam func_t FUNC_UNUSED6 = 3'd6;
  localparam func_t FUNC_UNUSED7 = 3'd7;
  localparam int    BIAS_FILL    = 0;
  localparam int    BIAS_DRAIN   = 1;
  localparam int    BIAS_MIX     = 2;

  typedef struct {
    word_t   data_out;
    status_t status;
    logic    last;
  } deq_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  word_t       shadow_words [DEPTH];
  int          shadow_front   = 0;
  int          shadow_count   = 0;
  deq_result_t pending_results [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;
  int          rx_mode        = 0;
  int          rx_mode_left   = 0;
  int          rx_stall_left  = 0;

  always #1 clk = ~clk;

  function automatic void queue_result(word_t d, status_t s, logic l);
    deq_result_t r;
    r.data_out = d;
    r.status   = s;
    r.last     = l;
    pending_results.push_back(r);
  endfunction

  // expected items for one accepted request, shadow deque updated in place
  function automatic void model_request(func_t f, word_t v);
    int off;
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else begin
          if (f == FUNC_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_words[shadow_front] = v;
          end else begin
            shadow_words[(shadow_front + shadow_count) % DEPTH] = v;
          end
          shadow_count++;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (shadow_count == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          if (f == FUNC_POP_FRONT) shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
          queue_result('0, STAT_OK, 1'b1);
        end
      end
      FUNC_DUMP_FWD, FUNC_DUMP_BWD: begin
        if (shadow_count == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            off = (f == FUNC_DUMP_FWD) ? i : shadow_count - 1 - i;
            queue_result(shadow_words[(shadow_front + off) % DEPTH], STAT_OK,
                         i == shadow_count - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_item(func_t f, word_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) :
                                                 $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    model_request(f, v);
    @(negedge clk);
  endtask

  task automatic test_empty_cases();
    send_item(FUNC_POP_FRONT, rand_word());
    send_item(FUNC_POP_BACK, rand_word());
    send_item(FUNC_DUMP_FWD, rand_word());
    send_item(FUNC_DUMP_BWD, rand_word());
    send_item(FUNC_UNUSED6, rand_word());
    send_item(FUNC_UNUSED7, rand_word());
  endtask

  task automatic test_extremes();
    send_item(FUNC_PUSH_BACK, 32'sh7fffffff);
    send_item(FUNC_PUSH_FRONT, 32'sh80000000);
    send_item(FUNC_PUSH_BACK, '0);
    send_item(FUNC_PUSH_FRONT, '1);
    send_item(FUNC_PUSH_BACK, 32'sh55555555);
    send_item(FUNC_PUSH_FRONT, 32'shaaaaaaaa);
    send_item(FUNC_DUMP_FWD, '1);
    send_item(FUNC_DUMP_BWD, '0);
    send_item(FUNC_POP_FRONT, '1);
    send_item(FUNC_POP_BACK, '1);
    send_item(FUNC_DUMP_FWD, '0);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_POP_BACK, '0);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_POP_BACK, '0);
    send_item(FUNC_POP_BACK, '0);
  endtask

  task automatic test_full_queue();
    while (shadow_count < DEPTH)
      send_item($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, rand_word());
    send_item(FUNC_PUSH_FRONT, rand_word());
    send_item(FUNC_PUSH_BACK, rand_word());
    send_item(FUNC_DUMP_FWD, rand_word());
    send_item(FUNC_DUMP_BWD, rand_word());
    send_item(FUNC_POP_FRONT, rand_word());
    send_item(FUNC_PUSH_BACK, rand_word());
    send_item(FUNC_PUSH_FRONT, rand_word());
    while (shadow_count > 0)
      send_item($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT, rand_word());
    send_item(FUNC_POP_FRONT, rand_word());
  endtask

  task automatic test_random_mix(int n);
    int    bias;
    int    phase_left;
    int    r;
    int    push_lim;
    int    pop_lim;
    func_t f;
    phase_left = 0;
    bias       = BIAS_MIX;
    for (int k = 0; k < n; k++) begin
      if (phase_left == 0) begin
        bias       = $urandom_range(BIAS_FILL, BIAS_MIX);
        phase_left = $urandom_range(15, 45);
      end
      phase_left--;
      case (bias)
        BIAS_FILL: begin
          push_lim = 70;
          pop_lim  = 85;
        end
        BIAS_DRAIN: begin
          push_lim = 20;
          pop_lim  = 85;
        end
        default: begin
          push_lim = 40;
          pop_lim  = 80;
        end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_lim) f = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      else if (r < pop_lim) f = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      else if (r < 95) f = $urandom_range(0, 1) ? FUNC_DUMP_BWD : FUNC_DUMP_FWD;
      else f = $urandom_range(0, 1) ? FUNC_UNUSED7 : FUNC_UNUSED6;
      send_item(f, rand_word());
    end
  endtask

  task automatic test_idle_until_drained();
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  // receiver back-pressure, switching at random among three stall modes
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(64, 256);
    end
    rx_mode_left--;
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
      rx_stall_left = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else if (rx_mode == 2 && $urandom_range(0, 1) == 0) begin
      rx_stall_left = $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: data_out %0d status %0d last %0d",
               out_ch.data_out, out_ch.status, out_ch.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data_out !== want.data_out) begin
          $error("data_out mismatch: expected %0d, actual %0d", want.data_out,
                 out_ch.data_out);
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("double_ended_queue_top test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_PUSH_FRONT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_cases();
    test_extremes();
    test_random_mix(50);
    test_idle_until_drained();
    test_full_queue();
    test_random_mix(50);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("double_ended_queue_top test passed");
    end else begin
      $display("double_ended_queue_top test failed");
    end
    $finish;
  end

endmodule
